// ----- rtl/cbs_pkg.sv -----
// Shared types and constants for the constant bandwidth server bank.
// Depends on nothing; imported by the top level constant_bandwidth_server.
package cbs_pkg;

   // Bank geometry.
   localparam int NUM_SERVERS = 4;
   localparam int QUEUE_DEPTH = 16;
   localparam int SRV_IDX_W   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

   // Field widths fixed by the interface.
   localparam int SRV_W   = 2;
   localparam int TIME_W  = 32;
   localparam int BUDG_W  = 16;
   localparam int JOB_W   = 5;

   // Queue limit at the width of the job counter.
   localparam logic [JOB_W-1:0] QUEUE_LIMIT = JOB_W'(QUEUE_DEPTH);
   // Number of servers at a width that can hold it next to a server index.
   localparam logic [SRV_W+4:0] SRV_COUNT   = (SRV_W + 5)'(NUM_SERVERS);

   // Operation codes of an input beat.
   typedef enum logic [1:0] {
      OP_INIT    = 2'd0,
      OP_TICK    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_DONE    = 2'd3
   } opcode_type;

   // One input beat as held in the input register.
   typedef struct packed {
      opcode_type          opcode;
      logic [SRV_W-1:0]    server;
      logic                server_valid;
      logic [TIME_W-1:0]   now;
      logic [BUDG_W-1:0]   quota;
      logic [BUDG_W-1:0]   period;
   } req_type;

endpackage

// ----- rtl/constant_bandwidth_server.sv -----
// Top level of the constant bandwidth server bank: per-server state and the
// update for init, tick, release and job-done beats.
// Depends on cbs_pkg.

// The block keeps quota, period, budget, deadline, idle flag and pending-job
// count for each server and answers every request beat with exactly one
// response beat that shows the addressed server's state after the update.
// One beat can be accepted every clock cycle while the response side is not
// stalled. A beat is held in an input register while the addressed server's
// state is read, updated and written back and the response is loaded into
// an output register; a stalled response side holds the beat there. The rate
// is set by that one read-modify-write of the per-server flip-flops, which
// finishes within the cycle, so back-to-back beats to the same server see
// each other's updates. On reset the idle flags are set and the job counts
// clear; quota, period, budget and deadline hold no value until an init beat
// writes them, and there is no clearing pass. Beats that name a server beyond
// the bank change nothing and return zeros in every field but the server
// index.
module constant_bandwidth_server
   import cbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic [SRV_W-1:0]    req_server,
   input  logic                req_server_valid,
   input  logic [TIME_W-1:0]   req_now,
   input  logic [BUDG_W-1:0]   req_quota,
   input  logic [BUDG_W-1:0]   req_period,
   // Response channel.
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SRV_W-1:0]    rsp_result_server,
   output logic [TIME_W-1:0]   rsp_deadline,
   output logic [BUDG_W-1:0]   rsp_remaining_budget,
   output logic                rsp_budget_spent,
   output logic                rsp_deadline_reset,
   output logic                rsp_server_idle,
   output logic [JOB_W-1:0]    rsp_pending_jobs,
   output logic                rsp_queue_overflow
);

   // Input register.
   req_type            req_ff;
   logic               req_valid_ff;

   // Per-server state.
   logic [BUDG_W-1:0]  quota_ff    [NUM_SERVERS];
   logic [BUDG_W-1:0]  period_ff   [NUM_SERVERS];
   logic [BUDG_W-1:0]  budget_ff   [NUM_SERVERS];
   logic [TIME_W-1:0]  deadline_ff [NUM_SERVERS];
   logic               idle_ff     [NUM_SERVERS];
   logic [JOB_W-1:0]   jobs_ff     [NUM_SERVERS];

   logic [BUDG_W-1:0]  quota_in    [NUM_SERVERS];
   logic [BUDG_W-1:0]  period_in   [NUM_SERVERS];
   logic [BUDG_W-1:0]  budget_in   [NUM_SERVERS];
   logic [TIME_W-1:0]  deadline_in [NUM_SERVERS];
   logic               idle_in     [NUM_SERVERS];
   logic [JOB_W-1:0]   jobs_in     [NUM_SERVERS];

   // Output register.
   logic               rsp_valid_ff;
   logic [SRV_W-1:0]   rsp_server_ff,   rsp_server_in;
   logic [TIME_W-1:0]  rsp_deadline_ff, rsp_deadline_in;
   logic [BUDG_W-1:0]  rsp_budget_ff,   rsp_budget_in;
   logic               rsp_exhaust_ff,  rsp_exhaust_in;
   logic               rsp_dreset_ff,   rsp_dreset_in;
   logic               rsp_idle_ff,     rsp_idle_in;
   logic [JOB_W-1:0]   rsp_jobs_ff,     rsp_jobs_in;
   logic               rsp_ovf_ff,      rsp_ovf_in;

   // Pipeline control.
   logic               advance;
   logic               load_req;

   // Addressed server and its current state.
   logic [SRV_IDX_W-1:0] idx;
   logic               in_range;
   logic [BUDG_W-1:0]  cur_quota;
   logic [BUDG_W-1:0]  cur_period;
   logic [BUDG_W-1:0]  cur_budget;
   logic [TIME_W-1:0]  cur_deadline;
   logic               cur_idle;
   logic [JOB_W-1:0]   cur_jobs;

   // Release rule terms.
   logic [TIME_W-1:0]        slack;
   logic [2*BUDG_W-1:0]      lhs_prod;
   logic [TIME_W+BUDG_W-1:0] rhs_prod;
   logic                     rule_holds;

   // The held beat moves on when the output register is free or being drained.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign load_req  = req_valid && req_ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (load_req) begin
         req_ff.opcode       <= opcode_type'(req_opcode);
         req_ff.server       <= req_server;
         req_ff.server_valid <= req_server_valid;
         req_ff.now          <= req_now;
         req_ff.quota        <= req_quota;
         req_ff.period       <= req_period;
      end
   end

   // Read of the addressed server.
   assign idx          = req_ff.server[SRV_IDX_W-1:0];
   assign in_range     = {5'b0, req_ff.server} < SRV_COUNT;
   assign cur_quota    = quota_ff[idx];
   assign cur_period   = period_ff[idx];
   assign cur_budget   = budget_ff[idx];
   assign cur_deadline = deadline_ff[idx];
   assign cur_idle     = idle_ff[idx];
   assign cur_jobs     = jobs_ff[idx];

   // Release rule budget*period >= (deadline-now)*quota. A deadline at or
   // before now gives a slack of zero or less, which always passes.
   assign slack      = cur_deadline - req_ff.now;
   assign lhs_prod   = {{BUDG_W{1'b0}}, cur_budget} * {{BUDG_W{1'b0}}, cur_period};
   assign rhs_prod   = {{BUDG_W{1'b0}}, slack} * {{TIME_W{1'b0}}, cur_quota};
   assign rule_holds = (cur_deadline <= req_ff.now) ||
                       ({{(TIME_W+BUDG_W-2*BUDG_W){1'b0}}, lhs_prod} >= rhs_prod);

   // Update of the addressed server and the response it produces.
   always_comb begin
      logic [BUDG_W-1:0] nxt_quota;
      logic [BUDG_W-1:0] nxt_period;
      logic [BUDG_W-1:0] nxt_budget;
      logic [TIME_W-1:0] nxt_deadline;
      logic              nxt_idle;
      logic [JOB_W-1:0]  nxt_jobs;
      logic              exhausted;
      logic              dreset;
      logic              overflow;

      quota_in    = quota_ff;
      period_in   = period_ff;
      budget_in   = budget_ff;
      deadline_in = deadline_ff;
      idle_in     = idle_ff;
      jobs_in     = jobs_ff;

      nxt_quota    = cur_quota;
      nxt_period   = cur_period;
      nxt_budget   = cur_budget;
      nxt_deadline = cur_deadline;
      nxt_idle     = cur_idle;
      nxt_jobs     = cur_jobs;
      exhausted    = 1'b0;
      dreset       = 1'b0;
      overflow     = 1'b0;

      unique case (req_ff.opcode)
         OP_INIT: begin
            nxt_quota    = req_ff.quota;
            nxt_period   = req_ff.period;
            nxt_budget   = req_ff.quota;
            nxt_deadline = '0;
            nxt_idle     = 1'b1;
            nxt_jobs     = '0;
         end
         OP_TICK: begin
            // A budget of one or less is spent: postpone and refill.
            if (req_ff.server_valid) begin
               if (cur_budget <= BUDG_W'(1)) begin
                  nxt_deadline = cur_deadline + {{(TIME_W-BUDG_W){1'b0}}, cur_period};
                  nxt_budget   = cur_quota;
                  exhausted    = 1'b1;
               end else begin
                  nxt_budget = cur_budget - BUDG_W'(1);
               end
            end
         end
         OP_RELEASE: begin
            if (cur_jobs == '0 && cur_idle && rule_holds) begin
               nxt_deadline = req_ff.now + {{(TIME_W-BUDG_W){1'b0}}, cur_period};
               nxt_budget   = cur_quota;
               dreset       = 1'b1;
            end
            nxt_idle = 1'b0;
            if (cur_jobs < QUEUE_LIMIT) begin
               nxt_jobs = cur_jobs + JOB_W'(1);
            end else begin
               overflow = 1'b1;
            end
         end
         OP_DONE: begin
            if (cur_jobs != '0) begin
               nxt_jobs = cur_jobs - JOB_W'(1);
            end
            if (nxt_jobs == '0) begin
               nxt_idle = 1'b1;
            end
         end
         default: begin
            nxt_jobs = cur_jobs;
         end
      endcase

      if (advance && in_range) begin
         quota_in[idx]    = nxt_quota;
         period_in[idx]   = nxt_period;
         budget_in[idx]   = nxt_budget;
         deadline_in[idx] = nxt_deadline;
         idle_in[idx]     = nxt_idle;
         jobs_in[idx]     = nxt_jobs;
      end

      // Out-of-range servers report zeros beside their index.
      rsp_server_in = req_ff.server;
      if (in_range) begin
         rsp_deadline_in = nxt_deadline;
         rsp_budget_in   = nxt_budget;
         rsp_exhaust_in  = exhausted;
         rsp_dreset_in   = dreset;
         rsp_idle_in     = nxt_idle;
         rsp_jobs_in     = nxt_jobs;
         rsp_ovf_in      = overflow;
      end else begin
         rsp_deadline_in = '0;
         rsp_budget_in   = '0;
         rsp_exhaust_in  = 1'b0;
         rsp_dreset_in   = 1'b0;
         rsp_idle_in     = 1'b0;
         rsp_jobs_in     = '0;
         rsp_ovf_in      = 1'b0;
      end
   end

   // Server state; only the idle flags and job counts have a reset value.
   always_ff @(posedge clock) begin
      quota_ff    <= quota_in;
      period_ff   <= period_in;
      budget_ff   <= budget_in;
      deadline_ff <= deadline_in;
      if (reset) begin
         for (int i = 0; i < NUM_SERVERS; i++) begin
            idle_ff[i] <= 1'b1;
            jobs_ff[i] <= '0;
         end
      end else begin
         idle_ff <= idle_in;
         jobs_ff <= jobs_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_server_ff   <= rsp_server_in;
         rsp_deadline_ff <= rsp_deadline_in;
         rsp_budget_ff   <= rsp_budget_in;
         rsp_exhaust_ff  <= rsp_exhaust_in;
         rsp_dreset_ff   <= rsp_dreset_in;
         rsp_idle_ff     <= rsp_idle_in;
         rsp_jobs_ff     <= rsp_jobs_in;
         rsp_ovf_ff      <= rsp_ovf_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_server    = rsp_server_ff;
   assign rsp_deadline         = rsp_deadline_ff;
   assign rsp_remaining_budget = rsp_budget_ff;
   assign rsp_budget_spent     = rsp_exhaust_ff;
   assign rsp_deadline_reset   = rsp_dreset_ff;
   assign rsp_server_idle      = rsp_idle_ff;
   assign rsp_pending_jobs     = rsp_jobs_ff;
   assign rsp_queue_overflow   = rsp_ovf_ff;

   // A reported job count never passes the queue depth.
   a_jobs_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pending_jobs <= QUEUE_LIMIT)
      else $error("job count above queue depth");

   // A server with queued jobs is never reported idle.
   a_busy_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pending_jobs != '0) |-> !rsp_server_idle)
      else $error("server idle with jobs pending");

   // Exhaustion comes from ticks and deadline resets from releases only.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_budget_spent && rsp_deadline_reset))
      else $error("exhausted and deadline reset in one beat");

   // A dropped job leaves the queue full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_queue_overflow) |-> rsp_pending_jobs == QUEUE_LIMIT)
      else $error("overflow reported on a queue that is not full");

   // A held beat always yields a response in the next cycle when not blocked.
   a_held_moves: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("held beat did not produce a response");

endmodule

// ----- bench/cbs_bookkeeper_pkg.sv -----
// Bookkeeping class for the constant bandwidth server bench: shadow state of every
// server, the answers it predicts for accepted request beats, and the response check.
// Depends on cbs_pkg for widths, the request struct and the operation codes.
`timescale 1ns / 100ps

package cbs_bookkeeper_pkg;
   import cbs_pkg::*;

   // One response beat as seen on the rsp_ ports.
   typedef struct packed {
      logic [SRV_W-1:0]  server;
      logic [TIME_W-1:0] deadline;
      logic [BUDG_W-1:0] budget;
      logic              exhausted;
      logic              fresh_deadline;
      logic              idle;
      logic [JOB_W-1:0]  jobs;
      logic              overflow;
   } answer_type;

   class cbs_bookkeeper;
      // Shadow copy of the per-server state.
      logic [BUDG_W-1:0] quota_of    [NUM_SERVERS];
      logic [BUDG_W-1:0] period_of   [NUM_SERVERS];
      logic [BUDG_W-1:0] budget_of   [NUM_SERVERS];
      logic [TIME_W-1:0] deadline_of [NUM_SERVERS];
      logic              idle_of     [NUM_SERVERS];
      int                jobs_of     [NUM_SERVERS];

      // Answers predicted for accepted beats, oldest first.
      answer_type awaited_answers[$];
      int mismatches;
      int answers_seen;

      function new();
         for (int i = 0; i < NUM_SERVERS; i++) begin
            quota_of[i]    = '0;
            period_of[i]   = '0;
            budget_of[i]   = '0;
            deadline_of[i] = '0;
            idle_of[i]     = 1'b1;
            jobs_of[i]     = 0;
         end
         mismatches   = 0;
         answers_seen = 0;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      // Apply one accepted request beat to the shadow state and queue its answer.
      function void note_request(req_type beat);
         answer_type a;
         int s;
         longint spent_side;
         longint slack;
         longint owed_side;
         a = '0;
         a.server = beat.server;
         s = int'(beat.server);
         if (s < NUM_SERVERS) begin
            case (beat.opcode)
               OP_INIT: begin
                  quota_of[s]    = beat.quota;
                  period_of[s]   = beat.period;
                  budget_of[s]   = beat.quota;
                  deadline_of[s] = '0;
                  idle_of[s]     = 1'b1;
                  jobs_of[s]     = 0;
               end
               OP_TICK: begin
                  // A budget of one or zero is spent out: postpone and refill.
                  if (beat.server_valid) begin
                     if (budget_of[s] <= 1) begin
                        deadline_of[s] = deadline_of[s] + TIME_W'(period_of[s]);
                        budget_of[s]   = quota_of[s];
                        a.exhausted    = 1'b1;
                     end else begin
                        budget_of[s] = budget_of[s] - 1'b1;
                     end
                  end
               end
               OP_RELEASE: begin
                  // A fresh deadline is due when the remaining budget would
                  // exceed the reserved bandwidth: compare cross-multiplied.
                  spent_side = longint'({48'b0, budget_of[s]});
                  spent_side = spent_side * longint'({48'b0, period_of[s]});
                  slack      = longint'({32'b0, deadline_of[s]});
                  slack      = slack - longint'({32'b0, beat.now});
                  owed_side  = slack * longint'({48'b0, quota_of[s]});
                  if (jobs_of[s] == 0 && idle_of[s] && spent_side >= owed_side) begin
                     deadline_of[s]   = beat.now + TIME_W'(period_of[s]);
                     budget_of[s]     = quota_of[s];
                     a.fresh_deadline = 1'b1;
                  end
                  idle_of[s] = 1'b0;
                  if (jobs_of[s] < QUEUE_DEPTH) jobs_of[s]++;
                  else a.overflow = 1'b1;
               end
               default: begin
                  if (jobs_of[s] > 0) jobs_of[s]--;
                  if (jobs_of[s] == 0) idle_of[s] = 1'b1;
               end
            endcase
            a.deadline = deadline_of[s];
            a.budget   = budget_of[s];
            a.idle     = idle_of[s];
            a.jobs     = JOB_W'(jobs_of[s]);
         end
         awaited_answers.push_back(a);
      endfunction

      task compare(string field, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("response %0d %s: got %0h, expected %0h",
                                      answers_seen, field, got, want));
      endtask

      // Check one accepted response beat against the oldest prediction.
      task check_response(answer_type got);
         answer_type want;
         answers_seen++;
         if (awaited_answers.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                      answers_seen));
            return;
         end
         want = awaited_answers.pop_front();
         compare("result_server", 64'(got.server), 64'(want.server));
         compare("deadline", 64'(got.deadline), 64'(want.deadline));
         compare("remaining_budget", 64'(got.budget), 64'(want.budget));
         compare("budget_spent", 64'(got.exhausted), 64'(want.exhausted));
         compare("deadline_reset", 64'(got.fresh_deadline), 64'(want.fresh_deadline));
         compare("server_idle", 64'(got.idle), 64'(want.idle));
         compare("pending_jobs", 64'(got.jobs), 64'(want.jobs));
         compare("queue_overflow", 64'(got.overflow), 64'(want.overflow));
      endtask
   endclass

endpackage

// ----- bench/tb_constant_bandwidth_server.sv -----
// Top-level bench for constant_bandwidth_server: drives init, tick, release and
// job-done beats with random gaps and response stalls, and checks every response.
// Depends on cbs_pkg, cbs_bookkeeper_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_constant_bandwidth_server;
   import cbs_pkg::*;
   import cbs_bookkeeper_pkg::*;

   localparam int RANDOM_BEATS   = 400;
   localparam int CALM_TAIL      = 60;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 500;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_opcode;
   logic [SRV_W-1:0]  req_server;
   logic              req_server_valid;
   logic [TIME_W-1:0] req_now;
   logic [BUDG_W-1:0] req_quota;
   logic [BUDG_W-1:0] req_period;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [SRV_W-1:0]  rsp_result_server;
   logic [TIME_W-1:0] rsp_deadline;
   logic [BUDG_W-1:0] rsp_remaining_budget;
   logic              rsp_budget_spent;
   logic              rsp_deadline_reset;
   logic              rsp_server_idle;
   logic [JOB_W-1:0]  rsp_pending_jobs;
   logic              rsp_queue_overflow;

   cbs_bookkeeper ledger = new();
   bit calm = 1'b0;
   int beats_sent = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   int ready_left = 0;

   constant_bandwidth_server u_dut (.*);

   // Clock, 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: bursts of stall between stretches of ready.
   always @(negedge clock) begin
      if (stall_left == 0 && ready_left == 0) begin
         if (!calm && $urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 14);
         else ready_left = $urandom_range(1, 24);
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         ready_left--;
      end
   end

   // Sample both channels at the rising edge; a watchdog guards against a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            ledger.note_request(req_type'{opcode: opcode_type'(req_opcode),
                                          server: req_server,
                                          server_valid: req_server_valid,
                                          now: req_now,
                                          quota: req_quota,
                                          period: req_period});
         if (rsp_valid && rsp_ready)
            ledger.check_response(answer_type'{server: rsp_result_server,
                                               deadline: rsp_deadline,
                                               budget: rsp_remaining_budget,
                                               exhausted: rsp_budget_spent,
                                               fresh_deadline: rsp_deadline_reset,
                                               idle: rsp_server_idle,
                                               jobs: rsp_pending_jobs,
                                               overflow: rsp_queue_overflow});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("[%0t] no beat moved for %0d cycles", $time, quiet_cycles);
               $display("FAILED: results differ");
               $finish;
            end
         end
      end
   end

   // Send one request beat, starting at a falling edge, with an optional gap
   // before it; returns at the falling edge after the beat was accepted.
   task automatic send_beat(opcode_type op, int s, logic running, logic [31:0] stamp,
                            logic [15:0] quota, logic [15:0] period);
      int gap;
      if (!calm && $urandom_range(0, 9) < 3) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_server       <= SRV_W'(s);
      req_server_valid <= running;
      req_now          <= stamp;
      req_quota        <= quota;
      req_period       <= period;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // Release stamp: anywhere, just before the current deadline, or within one of it.
   function automatic logic [31:0] pick_release_stamp(int s);
      case ($urandom_range(0, 2))
         0:       return $urandom;
         1:       return ledger.deadline_of[s]
                         - 32'($urandom_range(0, 2 * int'(ledger.period_of[s]) + 2));
         default: return ledger.deadline_of[s] + 32'($urandom_range(0, 2)) - 32'd1;
      endcase
   endfunction

   initial begin : stimulus
      int s;
      int n;
      int pick;
      int first_random;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_INIT;
      req_server       = '0;
      req_server_valid = 1'b0;
      req_now          = '0;
      req_quota        = '0;
      req_period       = '0;
      rsp_ready        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Load every server first, with the extremes of quota and period.
      send_beat(OP_INIT, 0, 1'b0, 32'd0, 16'd3, 16'd10);
      send_beat(OP_INIT, 1, 1'b1, 32'hFFFF_FFFF, 16'd0, 16'd0);
      send_beat(OP_INIT, 2, 1'b0, 32'd0, 16'hFFFF, 16'hFFFF);
      send_beat(OP_INIT, 3, 1'b1, 32'h5555_AAAA, 16'd1, 16'd1);
      // Tick while some other task runs, then spend server 0 down to exhaustion.
      send_beat(OP_TICK, 0, 1'b0, $urandom, 16'($urandom), 16'($urandom));
      repeat (3) send_beat(OP_TICK, 0, 1'b1, $urandom, 16'($urandom), 16'($urandom));
      // Tick on an empty budget and on a budget of one.
      send_beat(OP_TICK, 1, 1'b1, $urandom, 16'($urandom), 16'($urandom));
      send_beat(OP_TICK, 3, 1'b1, $urandom, 16'($urandom), 16'($urandom));
      // Release exactly on the bandwidth boundary, then at the top of time.
      send_beat(OP_RELEASE, 0, 1'b0, 32'd0, 16'($urandom), 16'($urandom));
      send_beat(OP_RELEASE, 2, 1'b1, 32'hFFFF_FFFF, 16'($urandom), 16'($urandom));
      // Release on a busy server, then drain it and finish once more when empty.
      send_beat(OP_RELEASE, 0, 1'b0, 32'd5, 16'($urandom), 16'($urandom));
      repeat (3) send_beat(OP_DONE, 0, 1'b1, $urandom, 16'($urandom), 16'($urandom));
      // Spend budget so that the old deadline is kept on the next release.
      repeat (2) send_beat(OP_TICK, 0, 1'b1, $urandom, 16'($urandom), 16'($urandom));
      send_beat(OP_RELEASE, 0, 1'b1, 32'd0, 16'($urandom), 16'($urandom));
      send_beat(OP_RELEASE, 1, 1'b0, 32'h8000_0000, 16'($urandom), 16'($urandom));
      send_beat(OP_DONE, 0, 1'b0, $urandom, 16'($urandom), 16'($urandom));

      // Random scenarios; the tail runs without gaps or stalls.
      first_random = beats_sent;
      while (beats_sent - first_random < RANDOM_BEATS) begin
         if (beats_sent - first_random >= RANDOM_BEATS - CALM_TAIL) calm = 1'b1;
         s    = $urandom_range(0, NUM_SERVERS - 1);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // New reservation: half of them tight so that budgets run out often.
            if ($urandom_range(0, 1))
               send_beat(OP_INIT, s, 1'($urandom), $urandom,
                         16'($urandom_range(1, 8)), 16'($urandom_range(1, 12)));
            else
               send_beat(OP_INIT, s, 1'($urandom), $urandom,
                         16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
         end else if (pick < 43) begin
            n = $urandom_range(1, 12);
            repeat (n) send_beat(OP_TICK, s, $urandom_range(0, 7) != 0,
                                 $urandom, 16'($urandom), 16'($urandom));
         end else if (pick < 68) begin
            send_beat(OP_RELEASE, s, 1'($urandom), pick_release_stamp(s),
                      16'($urandom), 16'($urandom));
         end else if (pick < 95) begin
            send_beat(OP_DONE, s, 1'($urandom), $urandom, 16'($urandom), 16'($urandom));
         end else begin
            // Flood the job queue with releases, up to or past its depth, then drain part or all of it.
            n = $urandom_range(15, 19);
            repeat (n) send_beat(OP_RELEASE, s, 1'($urandom), pick_release_stamp(s),
                                 16'($urandom), 16'($urandom));
            n = $urandom_range(0, 20);
            repeat (n) send_beat(OP_DONE, s, 1'($urandom), $urandom,
                                 16'($urandom), 16'($urandom));
         end
      end
      req_valid <= 1'b0;

      // Wait for every predicted response, then keep watching for strays.
      while (ledger.awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
